// ===== src/fixed_slot_allocator_macros.svh =====
// Assertion macros for the fixed slot allocator.
// Used by modules that own the clk and arst_n ports; no other dependencies.
`ifndef FIXED_SLOT_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fixed_slot_allocator: assertion failed");

// Next-cycle implication, disabled during reset.
`define FSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fixed_slot_allocator: assertion failed");

`endif

// ===== src/fsa_pkg.sv =====
// Shared types and constants for the fixed slot allocator.
// No dependencies.
package fsa_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int HANDLE_W  = $clog2(MAX_SLOTS);
	localparam int COUNT_W   = HANDLE_W + 1;
	localparam int CFG_W     = 11;
	localparam int PROD_W    = 2 * CFG_W;

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SLOTS);

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOMEM     = 2'd1,
		ST_BADHANDLE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		CFG_SLOTS_PER_PAGE = 1'b0,
		CFG_PAGE_LIMIT     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		func_t               func;
		logic [HANDLE_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle_out;
	} rsp_t;

	typedef struct packed {
		logic                we;
		logic                re;
		logic [HANDLE_W-1:0] waddr;
		logic [HANDLE_W-1:0] raddr;
		logic [HANDLE_W-1:0] wdata;
	} mem_req_t;

endpackage

// ===== src/fsa_stack_ram.sv =====
// Free stack storage: one write port, one registered read port.
// Depends on fsa_pkg.
module fsa_stack_ram
	import fsa_pkg::*;
(
	input  logic                clk,
	input  mem_req_t            mem_req,
	output logic [HANDLE_W-1:0] rd_data
);

	logic [HANDLE_W-1:0] mem [MAX_SLOTS];
	logic [HANDLE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_data_q <= mem[mem_req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/fsa_cfg.sv =====
// Configuration registers and registered fresh-slot capacity.
// Depends on fsa_pkg.
module fsa_cfg
	import fsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  cfg_idx_t           cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output logic [COUNT_W-1:0] capacity
);

	logic [CFG_W-1:0]   slots_per_page_q;
	logic [CFG_W-1:0]   page_limit_q;
	logic [COUNT_W-1:0] cap_q;
	logic [PROD_W-1:0]  prod;
	logic [COUNT_W-1:0] prod_sat;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_index == CFG_SLOTS_PER_PAGE) begin
			prod = PROD_W'(cfg_wdata) * PROD_W'(page_limit_q);
		end else begin
			prod = PROD_W'(slots_per_page_q) * PROD_W'(cfg_wdata);
		end
		if (prod > PROD_W'(MAX_SLOTS)) begin
			prod_sat = MAX_COUNT;
		end else begin
			prod_sat = prod[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_per_page_q <= CFG_W'(64);
			page_limit_q     <= CFG_W'(16);
			cap_q            <= MAX_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= prod_sat;
			case (cfg_index)
				CFG_SLOTS_PER_PAGE: slots_per_page_q <= cfg_wdata;
				CFG_PAGE_LIMIT:     page_limit_q     <= cfg_wdata;
				default:            page_limit_q     <= page_limit_q;
			endcase
		end
	end

	assign capacity = cap_q;

endmodule

// ===== src/fsa_ctrl.sv =====
// Allocate/free decision, stack pointer and issue counter, result pipeline.
// Depends on fsa_pkg and fixed_slot_allocator_macros.svh.
`include "fixed_slot_allocator_macros.svh"
module fsa_ctrl
	import fsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_t                req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp_data,
	input  logic [COUNT_W-1:0]  capacity,
	output mem_req_t            mem_req,
	input  logic [HANDLE_W-1:0] rd_data
);

	logic [COUNT_W-1:0]  depth_q;
	logic [COUNT_W-1:0]  issued_q;
	logic                valid_s1;
	logic                pop_s1;
	status_t             status_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                s1_move;
	logic                is_alloc;
	logic                pop;
	logic                fresh;
	logic                push;
	status_t             status_d;
	logic [COUNT_W-1:0]  depth_m1;

	assign s1_move   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !s1_move;
	assign accept    = req_valid && !req_stall;
	assign depth_m1  = depth_q - COUNT_W'(1);

	always_comb begin
		is_alloc = (req_data.func == FN_ALLOC);
		pop      = 1'b0;
		fresh    = 1'b0;
		push     = 1'b0;
		status_d = ST_OK;
		if (is_alloc) begin
			if (depth_q != '0) begin
				pop = 1'b1;
			end else if (issued_q < capacity) begin
				fresh = 1'b1;
			end else begin
				status_d = ST_NOMEM;
			end
		end else begin
			if (COUNT_W'(req_data.handle_in) >= issued_q) begin
				status_d = ST_BADHANDLE;
			end else if (depth_q == MAX_COUNT) begin
				status_d = ST_FULL;
			end else begin
				push = 1'b1;
			end
		end
	end

	always_comb begin
		mem_req.we    = accept && push;
		mem_req.re    = accept && pop;
		mem_req.waddr = depth_q[HANDLE_W-1:0];
		mem_req.raddr = depth_m1[HANDLE_W-1:0];
		mem_req.wdata = req_data.handle_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			issued_q    <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept && pop) begin
				depth_q <= depth_m1;
			end else if (accept && push) begin
				depth_q <= depth_q + COUNT_W'(1);
			end
			if (accept && fresh) begin
				issued_q <= issued_q + COUNT_W'(1);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1    <= pop;
			status_s1 <= status_d;
			handle_s1 <= fresh ? issued_q[HANDLE_W-1:0] : '0;
		end
		if (s1_move) begin
			rsp_q.status     <= status_s1;
			rsp_q.handle_out <= pop_s1 ? rd_data : handle_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`FSA_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= MAX_COUNT && issued_q <= MAX_COUNT)
	`FSA_ASSERT_NXT(a_pop_dec, accept && pop, depth_q == $past(depth_m1))
	`FSA_ASSERT_NOW(a_fail_zero, rsp_valid_q && rsp_q.status != ST_OK, rsp_q.handle_out == '0)
	`FSA_ASSERT_NOW(a_stall_busy, req_stall, valid_s1 && rsp_valid_q)

endmodule

// ===== src/fixed_slot_allocator.sv =====
// Fixed slot allocator: LIFO free stack in a one-port-write RAM, fresh issue counter.
// An accepted request passes through stage s1 and then the result register.
// Throughput: one request per cycle while req_stall is low; a pop reads the stack RAM at
// accept and its registered read data is muxed into the result register as s1 moves on.
// Reset clears the stack depth, issue count and valid flags and loads
// slots_per_page 64 and page_limit 16; stack RAM contents are not cleared.
module fixed_slot_allocator
	import fsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [COUNT_W-1:0]  capacity;
	mem_req_t            mem_req;
	logic [HANDLE_W-1:0] rd_data;

	fsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.capacity  (capacity)
	);

	fsa_stack_ram u_ram (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	fsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.capacity  (capacity),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

endmodule

// ===== bench/tb_fixed_slot_allocator.sv =====
// Self-checking bench for fixed_slot_allocator: a directed table and random traffic, checked
// against a cycle-free model of the free stack and issue counter kept in the bench.
// Depends on fsa_pkg and the fixed_slot_allocator RTL.
module tb_fixed_slot_allocator
	import fsa_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int NDIR = 26;

	typedef struct {
		bit                  is_cfg;
		cfg_idx_t            reg_idx;
		logic [CFG_W-1:0]    reg_val;
		func_t               op;
		logic [HANDLE_W-1:0] handle;
		bit                  typed;
		status_t             st;
		logic [HANDLE_W-1:0] hout;
	} stim_row_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req_data = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	cfg_idx_t         cfg_index = CFG_SLOTS_PER_PAGE;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic [CFG_W-1:0]    spp_reg = CFG_W'(64);
	logic [CFG_W-1:0]    plim_reg = CFG_W'(16);
	int                  pool_issued = 0;
	int                  pool_depth = 0;
	logic [HANDLE_W-1:0] pool_stack [MAX_SLOTS];

	rsp_t      expected_rsp [$];
	int        fail_count = 0;
	int        cycle_count = 0;
	int        hold_cnt = 0;
	bit        calm = 1'b0;
	stim_row_t dir_rows [NDIR];

	fixed_slot_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL fixed_slot_allocator");
		$finish;
	end

	function automatic int pick_wait();
		return calm ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic rsp_t slot_pool_step(req_t r);
		rsp_t o;
		int cap;
		o.status = ST_OK;
		o.handle_out = '0;
		cap = int'(plim_reg) * int'(spp_reg);
		if (cap > MAX_SLOTS)
			cap = MAX_SLOTS;
		if (r.func == FN_ALLOC) begin
			if (pool_depth > 0) begin
				pool_depth--;
				o.handle_out = pool_stack[pool_depth];
			end else if (pool_issued < cap) begin
				o.handle_out = HANDLE_W'(pool_issued);
				pool_issued++;
			end else begin
				o.status = ST_NOMEM;
			end
		end else if (int'(r.handle_in) >= pool_issued) begin
			o.status = ST_BADHANDLE;
		end else if (pool_depth >= MAX_SLOTS) begin
			o.status = ST_FULL;
		end else begin
			pool_stack[pool_depth] = r.handle_in;
			pool_depth++;
		end
		return o;
	endfunction

	function automatic stim_row_t req_row(func_t f, int h, bit typed, status_t st, int ho);
		stim_row_t s;
		s.is_cfg = 1'b0;
		s.reg_idx = CFG_SLOTS_PER_PAGE;
		s.reg_val = '0;
		s.op = f;
		s.handle = HANDLE_W'(h);
		s.typed = typed;
		s.st = st;
		s.hout = HANDLE_W'(ho);
		return s;
	endfunction

	function automatic stim_row_t cfg_row(cfg_idx_t i, int v);
		stim_row_t s;
		s = req_row(FN_ALLOC, 0, 1'b0, ST_OK, 0);
		s.is_cfg = 1'b1;
		s.reg_idx = i;
		s.reg_val = CFG_W'(v);
		return s;
	endfunction

	function automatic logic [HANDLE_W-1:0] issued_handle();
		if (pool_issued == 0)
			return HANDLE_W'($urandom);
		return HANDLE_W'($urandom_range(0, pool_issued - 1));
	endfunction

	task automatic drain_results();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SLOTS_PER_PAGE)
			spp_reg = val;
		else
			plim_reg = val;
		@(posedge clk);
	endtask

	task automatic issue_request(req_t r, bit typed, rsp_t typed_rsp);
		int gap;
		rsp_t predicted;
		gap = pick_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (req_stall);
		predicted = slot_pool_step(r);
		expected_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic random_request(int alloc_pct, int good_pct);
		req_t r;
		if ($urandom_range(0, 99) < alloc_pct) begin
			r.func = FN_ALLOC;
			r.handle_in = HANDLE_W'($urandom);
		end else begin
			r.func = FN_FREE;
			if ($urandom_range(0, 99) < good_pct)
				r.handle_in = issued_handle();
			else
				r.handle_in = HANDLE_W'($urandom_range(0, MAX_SLOTS - 1));
		end
		issue_request(r, 1'b0, '0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_cnt = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected transaction: status %0d handle_out %0d",
						rsp_data.status, rsp_data.handle_out);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_data.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_data.status);
						fail_count++;
					end
					if (rsp_data.handle_out !== want.handle_out) begin
						$error("handle_out: expected %0d, actual %0d",
							want.handle_out, rsp_data.handle_out);
						fail_count++;
					end
				end
				hold_cnt = pick_wait();
			end else if (hold_cnt > 0) begin
				hold_cnt--;
			end
			rsp_stall <= (hold_cnt > 0);
		end
	end

	initial begin
		int n;
		req_t r;
		int spp_set [6];
		int plim_set [6];
		dir_rows = '{
			req_row(FN_FREE, 0, 1'b1, ST_BADHANDLE, 0),
			req_row(FN_ALLOC, 0, 1'b1, ST_OK, 0),
			req_row(FN_ALLOC, 1023, 1'b1, ST_OK, 1),
			req_row(FN_FREE, 1023, 1'b1, ST_BADHANDLE, 0),
			req_row(FN_FREE, 1, 1'b1, ST_OK, 0),
			req_row(FN_FREE, 1, 1'b1, ST_OK, 0),
			req_row(FN_ALLOC, 0, 1'b1, ST_OK, 1),
			req_row(FN_ALLOC, 0, 1'b1, ST_OK, 1),
			req_row(FN_ALLOC, 0, 1'b1, ST_OK, 2),
			cfg_row(CFG_SLOTS_PER_PAGE, 1),
			cfg_row(CFG_PAGE_LIMIT, 3),
			req_row(FN_ALLOC, 0, 1'b1, ST_NOMEM, 0),
			req_row(FN_FREE, 2, 1'b0, ST_OK, 0),
			req_row(FN_ALLOC, 0, 1'b0, ST_OK, 0),
			cfg_row(CFG_SLOTS_PER_PAGE, 0),
			req_row(FN_ALLOC, 0, 1'b1, ST_NOMEM, 0),
			req_row(FN_FREE, 3, 1'b1, ST_BADHANDLE, 0),
			req_row(FN_FREE, 0, 1'b0, ST_OK, 0),
			cfg_row(CFG_SLOTS_PER_PAGE, 1024),
			cfg_row(CFG_PAGE_LIMIT, 1024),
			req_row(FN_ALLOC, 0, 1'b0, ST_OK, 0),
			req_row(FN_ALLOC, 0, 1'b0, ST_OK, 0),
			cfg_row(CFG_SLOTS_PER_PAGE, 2047),
			cfg_row(CFG_PAGE_LIMIT, 2047),
			req_row(FN_ALLOC, 0, 1'b0, ST_OK, 0),
			req_row(FN_FREE, 1023, 1'b1, ST_BADHANDLE, 0)
		};
		spp_set = '{1, 0, 7, 1024, 5, 2047};
		plim_set = '{1, 5, 3, 1, 0, 2047};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				r.func = dir_rows[i].op;
				r.handle_in = dir_rows[i].handle;
				issue_request(r, dir_rows[i].typed,
					'{status: dir_rows[i].st, handle_out: dir_rows[i].hout});
			end
		end

		// grow the issued range, back to back for a stretch
		write_reg(CFG_SLOTS_PER_PAGE, CFG_W'(32));
		write_reg(CFG_PAGE_LIMIT, CFG_W'(32));
		n = 0;
		while (pool_issued < 64) begin
			n++;
			calm = (n >= 10 && n < 25);
			if (n == 30)
				drain_results();
			random_request(92, 80);
		end
		calm = 1'b0;

		// fill the free stack to the top, overflow it, then unwind
		while (pool_depth < MAX_SLOTS)
			random_request(0, 100);
		repeat (8) random_request(0, 95);
		repeat (20) random_request(50, 90);

		foreach (spp_set[k]) begin
			write_reg(CFG_SLOTS_PER_PAGE, CFG_W'(spp_set[k]));
			write_reg(CFG_PAGE_LIMIT, CFG_W'(plim_set[k]));
			calm = (k == 2);
			repeat (8) random_request(50, 85);
		end
		calm = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS fixed_slot_allocator");
		else
			$display("FAIL fixed_slot_allocator");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/fsa_pkg.sv
src/fsa_stack_ram.sv
src/fsa_cfg.sv
src/fsa_ctrl.sv
src/fixed_slot_allocator.sv
bench/tb_fixed_slot_allocator.sv
